FILE: sv/swept_aabb_contact_direction_unit_defines.svh
// ----------------------------------------------------------------------------
// swept aabb contact direction unit - assertion macros
// shared property wrappers for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SWEPT_AABB_CONTACT_DIRECTION_UNIT_DEFINES_SVH
`define SWEPT_AABB_CONTACT_DIRECTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// shared types, constants and helpers of the swept box contact unit
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int SacW        = 32;
    localparam int SacDivSteps = 17;
    localparam int SacTimeW    = 17;
    localparam int SacLanes    = 4;

    // saturated axis time, larger than any frame time
    localparam logic [SacTimeW-1:0] SatTime = 17'h10000;

    localparam logic [15:0] FrameTimeReset = 16'd1092;

    // register index decoded from paddr[2]
    localparam logic RegFrameTime = 1'b0;

    // lanes of the divider array
    localparam int LaneXIn  = 0;
    localparam int LaneXOut = 1;
    localparam int LaneYIn  = 2;
    localparam int LaneYOut = 3;

    // contact direction codes
    localparam logic [3:0] DirNone        = 4'd0;
    localparam logic [3:0] DirTopLeft     = 4'd1;
    localparam logic [3:0] DirTopRight    = 4'd2;
    localparam logic [3:0] DirTop         = 4'd3;
    localparam logic [3:0] DirBottomLeft  = 4'd4;
    localparam logic [3:0] DirBottomRight = 4'd5;
    localparam logic [3:0] DirBottom      = 4'd6;
    localparam logic [3:0] DirLeft        = 4'd7;
    localparam logic [3:0] DirRight       = 4'd8;

    // one divider lane: partial remainder, next dividend bit, divisor, overflow
    typedef struct packed {
        logic [SacW-1:0] rem;
        logic            nbit;
        logic [SacW-1:0] spd;
        logic            ovf;
    } t_lane;

    // per-item control that travels beside the dividers
    typedef struct packed {
        logic       apart;
        logic       rej;
        logic       en_xin;
        logic       en_xout;
        logic       en_yin;
        logic       en_yout;
        logic [3:0] dir;
    } t_side;

    // signed 32-bit difference at full 33-bit width
    function automatic logic signed [SacW:0] f_sub33(
        input logic signed [SacW-1:0] a,
        input logic signed [SacW-1:0] b
    );
        f_sub33 = {a[SacW-1], a} - {b[SacW-1], b};
    endfunction

endpackage

FILE: sv/sac_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_prep
// front pipeline: input capture, edge tests and gaps, divider setup
// ----------------------------------------------------------------------------
module sac_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [15:0]                 i_frame_time,
    input  logic signed [31:0]          i_a_min_x,
    input  logic signed [31:0]          i_a_min_y,
    input  logic signed [31:0]          i_a_max_x,
    input  logic signed [31:0]          i_a_max_y,
    input  logic signed [31:0]          i_b_min_x,
    input  logic signed [31:0]          i_b_min_y,
    input  logic signed [31:0]          i_b_max_x,
    input  logic signed [31:0]          i_b_max_y,
    input  logic signed [31:0]          i_rel_vel_x,
    input  logic signed [31:0]          i_rel_vel_y,
    input  logic signed [31:0]          i_a_pos_x,
    input  logic signed [31:0]          i_b_pos_x,
    output logic                        o_valid,
    output sac_pkg::t_lane              o_lane [sac_pkg::SacLanes],
    output sac_pkg::t_side              o_side
);
    import sac_pkg::*;

    // stage 1: captured transaction
    logic              r1_v;
    logic signed [31:0] r1_aminx, r1_aminy, r1_amaxx, r1_amaxy;
    logic signed [31:0] r1_bminx, r1_bminy, r1_bmaxx, r1_bmaxy;
    logic signed [31:0] r1_vx, r1_vy, r1_pa, r1_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_aminx <= i_a_min_x;
            r1_aminy <= i_a_min_y;
            r1_amaxx <= i_a_max_x;
            r1_amaxy <= i_a_max_y;
            r1_bminx <= i_b_min_x;
            r1_bminy <= i_b_min_y;
            r1_bmaxx <= i_b_max_x;
            r1_bmaxy <= i_b_max_y;
            r1_vx    <= i_rel_vel_x;
            r1_vy    <= i_rel_vel_y;
            r1_pa    <= i_a_pos_x;
            r1_pb    <= i_b_pos_x;
        end
    end

    // stage 2 logic: edge tests, per-axis gaps, speeds, drift product
    logic        ltx, gtx, lty, gty, negx, negy, zx, zy;
    logic signed [32:0] n_gxin, n_gxout, n_gyin, n_gyout, n_spx, n_spy;
    logic signed [48:0] n_drift;

    always_comb begin
        ltx  = r1_amaxx < r1_bminx;
        gtx  = r1_aminx > r1_bmaxx;
        lty  = r1_amaxy < r1_bminy;
        gty  = r1_aminy > r1_bmaxy;
        negx = r1_vx[31];
        negy = r1_vy[31];
        zx   = (r1_vx == 32'sd0);
        zy   = (r1_vy == 32'sd0);
        n_gxin  = negx ? f_sub33(r1_bminx, r1_amaxx) : f_sub33(r1_aminx, r1_bmaxx);
        n_gxout = negx ? f_sub33(r1_bmaxx, r1_aminx) : f_sub33(r1_amaxx, r1_bminx);
        n_gyin  = negy ? f_sub33(r1_bminy, r1_amaxy) : f_sub33(r1_aminy, r1_bmaxy);
        n_gyout = negy ? f_sub33(r1_bmaxy, r1_aminy) : f_sub33(r1_amaxy, r1_bminy);
        n_spx   = negx ? f_sub33(32'sd0, r1_vx) : {1'b0, r1_vx};
        n_spy   = negy ? f_sub33(32'sd0, r1_vy) : {1'b0, r1_vy};
        n_drift = r1_vy * $signed({1'b0, i_frame_time});
    end

    // stage 2 registers
    logic              r2_v;
    logic              r2_apart, r2_rej;
    logic              r2_exin, r2_exout, r2_eyin, r2_eyout;
    logic [31:0]       r2_gxin, r2_gxout, r2_gyin, r2_gyout, r2_spx, r2_spy;
    logic signed [32:0] r2_dytop, r2_dybot;
    logic signed [48:0] r2_drift;
    logic              r2_pgt, r2_plt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_apart <= ltx | gtx | lty | gty;
            r2_rej   <= (negx ? gtx : (zx ? (ltx | gtx) : ltx)) |
                        (negy ? gty : (zy ? (lty | gty) : lty));
            r2_exin  <= negx ? ltx : (!zx & gtx);
            r2_exout <= negx ? (r1_aminx < r1_bmaxx) : (!zx & (r1_amaxx > r1_bminx));
            r2_eyin  <= negy ? lty : (!zy & gty);
            r2_eyout <= negy ? (r1_aminy < r1_bmaxy) : (!zy & (r1_amaxy > r1_bminy));
            r2_gxin  <= n_gxin[31:0];
            r2_gxout <= n_gxout[31:0];
            r2_gyin  <= n_gyin[31:0];
            r2_gyout <= n_gyout[31:0];
            r2_spx   <= n_spx[31:0];
            r2_spy   <= n_spy[31:0];
            r2_dytop <= f_sub33(r1_amaxy, r1_bminy);
            r2_dybot <= f_sub33(r1_aminy, r1_bmaxy);
            r2_drift <= n_drift;
            r2_pgt   <= r1_pa > r1_pb;
            r2_plt   <= r1_pa < r1_pb;
        end
    end

    // stage 3 logic: direction group and divider setup
    logic signed [49:0] n_top, n_bot;
    logic [3:0]         n_dir;
    logic [31:0]        w_gap [SacLanes];
    logic [31:0]        w_spd [SacLanes];

    always_comb begin
        n_top = $signed({r2_dytop, 16'd0}) + 50'(r2_drift);
        n_bot = $signed({r2_dybot, 16'd0}) + 50'(r2_drift);
        if (n_top[49]) begin
            n_dir = r2_pgt ? DirTopLeft : (r2_plt ? DirTopRight : DirTop);
        end else if (!n_bot[49] && (n_bot != 50'sd0)) begin
            n_dir = r2_pgt ? DirBottomLeft : (r2_plt ? DirBottomRight : DirBottom);
        end else begin
            n_dir = r2_pgt ? DirLeft : (r2_plt ? DirRight : DirNone);
        end
        w_gap[LaneXIn]  = r2_gxin;
        w_gap[LaneXOut] = r2_gxout;
        w_gap[LaneYIn]  = r2_gyin;
        w_gap[LaneYOut] = r2_gyout;
        w_spd[LaneXIn]  = r2_spx;
        w_spd[LaneXOut] = r2_spx;
        w_spd[LaneYIn]  = r2_spy;
        w_spd[LaneYOut] = r2_spy;
    end

    // stage 3 registers
    logic  r3_v;
    t_side r3_side;
    t_lane r3_lane [SacLanes];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side.apart   <= r2_apart;
            r3_side.rej     <= r2_rej;
            r3_side.en_xin  <= r2_exin;
            r3_side.en_xout <= r2_exout;
            r3_side.en_yin  <= r2_eyin;
            r3_side.en_yout <= r2_eyout;
            r3_side.dir     <= n_dir;
            for (int k = 0; k < SacLanes; k++) begin
                r3_lane[k].rem  <= {1'b0, w_gap[k][31:1]};
                r3_lane[k].nbit <= w_gap[k][0];
                r3_lane[k].spd  <= w_spd[k];
                r3_lane[k].ovf  <= {1'b0, w_gap[k]} >= {w_spd[k], 1'b0};
            end
        end
    end

    assign o_valid = r3_v;
    assign o_lane  = r3_lane;
    assign o_side  = r3_side;

endmodule

FILE: sv/sac_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_div_pipe
// pipelined restoring divider, one quotient bit per stage, saturating time
// ----------------------------------------------------------------------------
module sac_div_pipe (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  sac_pkg::t_lane                 i_lane,
    output logic [sac_pkg::SacTimeW-1:0]   o_time
);
    import sac_pkg::*;

    logic [SacW-1:0]        r_rem [SacDivSteps];
    logic [SacW-1:0]        r_spd [SacDivSteps];
    logic [SacDivSteps-1:0] r_q   [SacDivSteps];
    logic                   r_ovf [SacDivSteps];

    for (genvar k = 0; k < SacDivSteps; k++) begin : g_step
        logic [SacW-1:0]        w_rem;
        logic                   w_bit;
        logic [SacW-1:0]        w_spd;
        logic [SacDivSteps-1:0] w_q;
        logic                   w_ovf;
        logic [SacW:0]          w_par;
        logic [SacW:0]          w_dif;
        logic                   w_ge;

        // operands from the lane input or the previous stage
        if (k == 0) begin : g_first
            assign w_rem = i_lane.rem;
            assign w_bit = i_lane.nbit;
            assign w_spd = i_lane.spd;
            assign w_q   = '0;
            assign w_ovf = i_lane.ovf;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_bit = 1'b0;
            assign w_spd = r_spd[k-1];
            assign w_q   = r_q[k-1];
            assign w_ovf = r_ovf[k-1];
        end

        // one trial subtraction
        assign w_par = {w_rem, w_bit};
        assign w_ge  = w_par >= {1'b0, w_spd};
        assign w_dif = w_par - {1'b0, w_spd};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_dif[SacW-1:0] : w_par[SacW-1:0];
                r_spd[k] <= w_spd;
                r_q[k]   <= {w_q[SacDivSteps-2:0], w_ge};
                r_ovf[k] <= w_ovf;
            end
        end
    end

    assign o_time = r_ovf[SacDivSteps-1] ? SatTime : r_q[SacDivSteps-1];

endmodule

FILE: sv/swept_aabb_contact_direction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_contact_direction_unit
// swept 2d box contact test with contact direction; when not stalled, one box pair per cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid / o_ready carries one box pair per transaction;
//   output channel o_valid / i_ready returns o_hit and o_direction.
//   frame_time sits at apb address 0; the user writes it only while the unit is idle (not enforced).
// throughput: one transaction per cycle while o_ready is high.
// pipeline: a result reaches o_valid through three front stages (the first
//   loads at the accepting edge), 17 divider stages (one quotient bit each,
//   four lanes in parallel), and the output register.
// reset: all valid bits clear, frame_time returns to 1092.
// stall: a two-entry output stage (output register plus skid) takes the
//   result; the whole pipeline holds while the skid entry is occupied, and
//   o_ready is low in exactly those cycles. nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "swept_aabb_contact_direction_unit_defines.svh"

module swept_aabb_contact_direction_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_a_min_x,
    input  logic signed [31:0] i_a_min_y,
    input  logic signed [31:0] i_a_max_x,
    input  logic signed [31:0] i_a_max_y,
    input  logic signed [31:0] i_b_min_x,
    input  logic signed [31:0] i_b_min_y,
    input  logic signed [31:0] i_b_max_x,
    input  logic signed [31:0] i_b_max_y,
    input  logic signed [31:0] i_rel_vel_x,
    input  logic signed [31:0] i_rel_vel_y,
    input  logic signed [31:0] i_a_pos_x,
    input  logic signed [31:0] i_b_pos_x,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [3:0]         o_direction,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sac_pkg::*;

    // configuration register
    logic [15:0] r_frame_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= FrameTimeReset;
        end else if (psel && penable && pwrite && (paddr[2] == RegFrameTime)) begin
            r_frame_time <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegFrameTime) ? {16'd0, r_frame_time} : 32'd0;

    // pipeline enable: hold while the skid entry is full
    logic r_skd_v;
    logic w_en;
    assign w_en    = !r_skd_v;
    assign o_ready = w_en;

    // front stages
    logic  w_pv;
    t_lane w_lane [SacLanes];
    t_side w_side;

    sac_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_frame_time (r_frame_time),
        .i_a_min_x    (i_a_min_x),
        .i_a_min_y    (i_a_min_y),
        .i_a_max_x    (i_a_max_x),
        .i_a_max_y    (i_a_max_y),
        .i_b_min_x    (i_b_min_x),
        .i_b_min_y    (i_b_min_y),
        .i_b_max_x    (i_b_max_x),
        .i_b_max_y    (i_b_max_y),
        .i_rel_vel_x  (i_rel_vel_x),
        .i_rel_vel_y  (i_rel_vel_y),
        .i_a_pos_x    (i_a_pos_x),
        .i_b_pos_x    (i_b_pos_x),
        .o_valid      (w_pv),
        .o_lane       (w_lane),
        .o_side       (w_side)
    );

    // divider lanes
    logic [SacTimeW-1:0] w_time [SacLanes];

    for (genvar l = 0; l < SacLanes; l++) begin : g_lane
        sac_div_pipe u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_lane[l]),
            .o_time (w_time[l])
        );
    end

    // control line beside the dividers
    logic  r_sd_v [SacDivSteps];
    t_side r_sd   [SacDivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SacDivSteps; k++) begin
                r_sd_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_sd_v[0] <= w_pv;
            for (int k = 1; k < SacDivSteps; k++) begin
                r_sd_v[k] <= r_sd_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= w_side;
            for (int k = 1; k < SacDivSteps; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // final combine: latest entry, earliest exit, frame limit
    t_side               w_ls;
    logic [SacTimeW-1:0] w_ft, w_tin, w_tout, w_tx, w_ty;
    logic                w_hit;
    logic [3:0]          w_dir;

    always_comb begin
        w_ls   = r_sd[SacDivSteps-1];
        w_ft   = {1'b0, r_frame_time};
        w_tx   = w_ls.en_xin ? w_time[LaneXIn] : '0;
        w_ty   = w_ls.en_yin ? w_time[LaneYIn] : '0;
        w_tin  = (w_tx > w_ty) ? w_tx : w_ty;
        w_tout = w_ft;
        if (w_ls.en_xout && (w_time[LaneXOut] < w_tout)) begin
            w_tout = w_time[LaneXOut];
        end
        if (w_ls.en_yout && (w_time[LaneYOut] < w_tout)) begin
            w_tout = w_time[LaneYOut];
        end
        w_hit = !w_ls.apart || (!w_ls.rej && (w_tin <= w_tout) && (w_tin <= w_ft));
        w_dir = w_hit ? w_ls.dir : DirNone;
    end

    // output register and skid entry
    logic       w_push, w_pop;
    logic       r_out_v, r_out_hit, r_skd_hit;
    logic [3:0] r_out_dir, r_skd_dir;

    assign w_push = w_en && r_sd_v[SacDivSteps-1];
    assign w_pop  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (w_pop) begin
                r_skd_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out_v <= 1'b1;
            end else begin
                r_skd_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (w_pop) begin
                r_out_hit <= r_skd_hit;
                r_out_dir <= r_skd_dir;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out_hit <= w_hit;
                r_out_dir <= w_dir;
            end else begin
                r_skd_hit <= w_hit;
                r_skd_dir <= w_dir;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_hit       = r_out_hit;
    assign o_direction = r_out_dir;

    // checks
    `SAC_ASSERT_SAME(a_skd_needs_out, r_skd_v, r_out_v, "skid full with empty output")
    `SAC_ASSERT_SAME(a_miss_no_dir, o_valid && !o_hit, o_direction == DirNone, "direction on miss")
    `SAC_ASSERT_NEXT(a_stall_to_skid, w_push && r_out_v && !i_ready, r_skd_v, "stalled result lost")

endmodule
